// ===== sv/sle_pkg.sv =====
package sle_pkg;

   // key codes
   localparam logic [7:0] KEY_HOME   = 8'h01;
   localparam logic [7:0] KEY_BACK   = 8'h02;
   localparam logic [7:0] KEY_DEL    = 8'h04;
   localparam logic [7:0] KEY_END    = 8'h05;
   localparam logic [7:0] KEY_FWD    = 8'h06;
   localparam logic [7:0] KEY_BS     = 8'h08;
   localparam logic [7:0] KEY_TAB    = 8'h09;
   localparam logic [7:0] KEY_LF     = 8'h0A;
   localparam logic [7:0] KEY_CR     = 8'h0D;
   localparam logic [7:0] KEY_KILL   = 8'h15;
   localparam logic [7:0] KEY_RUBOUT = 8'h7F;

   // echo characters
   localparam logic [7:0] CH_BELL  = 8'h07;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam int CAP_W = 5;
   localparam int LEN_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef logic [3:0] op_type;
   localparam op_type OP_CHAR = 4'd0;
   localparam op_type OP_KILL = 4'd1;
   localparam op_type OP_HOME = 4'd2;
   localparam op_type OP_BACK = 4'd3;
   localparam op_type OP_FWD  = 4'd4;
   localparam op_type OP_END  = 4'd5;
   localparam op_type OP_BKSP = 4'd6;
   localparam op_type OP_DEL  = 4'd7;
   localparam op_type OP_INS  = 4'd8;
   localparam op_type OP_EOL  = 4'd9;

   typedef struct packed {
      op_type     op;
      logic [7:0] key;
   } cmd_type;

endpackage

// ===== sv/serial_line_editor_core.sv =====
// Line editor for a serial terminal. Key bytes go in through req_push/req_full, and the
// echo bytes (out_kind 0) and finished-line bytes (out_kind 1) come out one item at a time
// through rsp_empty/rsp_pop; rsp_last marks the final item caused by a key, and on CR or LF
// that item also carries line_done and line_length. csr_line_capacity sets the line limit
// (clamped to LINE_CHARS) and is always ready; write it only while no key is in flight.
// A key is first dispatched from the queue. Each fixed echo byte (backspace, space, bell,
// CR, LF) is then emitted directly, and each byte from the single-port line store is first
// read and then emitted, since the store's read data is registered. A run of backspaces or
// spaces and a delete's shift loop each end with an exit check; a delete shifts the
// characters behind the cursor left, and an insert shifts them right before its echo.
// A two-entry key queue lets keys arrive while one executes; a stalled result output holds
// the sequencer, and key intake stops once the queue is full.
module serial_line_editor_core #(
   parameter int LINE_CHARS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [7:0]                req_key_byte,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_out_kind,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_line_done,
   output logic [sle_pkg::LEN_W-1:0] rsp_line_length,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [sle_pkg::CAP_W-1:0] csr_line_capacity
);
   import sle_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_head;

   assign csr_ready = 1'b1;

   sle_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_key_byte (req_key_byte),
      .cmd_valid    (cmd_valid),
      .cmd_head     (cmd_head),
      .cmd_pop      (cmd_pop)
   );

   sle_back #(
      .LINE_CHARS (LINE_CHARS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd_head          (cmd_head),
      .cmd_pop           (cmd_pop),
      .csr_valid         (csr_valid),
      .csr_line_capacity (csr_line_capacity),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_line_done     (rsp_line_done),
      .rsp_line_length   (rsp_line_length),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== sv/sle_front.sv =====
module sle_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_key_byte,
   output logic             cmd_valid,
   output sle_pkg::cmd_type cmd_head,
   input  logic             cmd_pop
);
   import sle_pkg::*;

   cmd_type    q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    decoded;
   logic       push_ok;
   logic       pop_ok;

   always_comb begin
      decoded.key = req_key_byte;
      unique case (req_key_byte) inside
         KEY_KILL:           decoded.op = OP_KILL;
         KEY_HOME:           decoded.op = OP_HOME;
         KEY_BACK:           decoded.op = OP_BACK;
         KEY_FWD:            decoded.op = OP_FWD;
         KEY_END:            decoded.op = OP_END;
         KEY_BS, KEY_RUBOUT: decoded.op = OP_BKSP;
         KEY_DEL:            decoded.op = OP_DEL;
         KEY_TAB:            decoded.op = OP_INS;
         KEY_CR, KEY_LF:     decoded.op = OP_EOL;
         default:            decoded.op = OP_CHAR;
      endcase
   end

   assign req_full  = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_head  = q_ff[rptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wptr_in = push_ok ? !wptr_ff : wptr_ff;
      rptr_in = pop_ok ? !rptr_ff : rptr_ff;
      fill_in = fill_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wptr_ff] <= decoded;
      end
   end

endmodule

// ===== sv/sle_back.sv =====
module sle_back #(
   parameter int LINE_CHARS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  sle_pkg::cmd_type          cmd_head,
   output logic                      cmd_pop,
   input  logic                      csr_valid,
   input  logic [sle_pkg::CAP_W-1:0] csr_line_capacity,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_out_kind,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_line_done,
   output logic [sle_pkg::LEN_W-1:0] rsp_line_length,
   output logic                      rsp_last
);
   import sle_pkg::*;

   localparam int PW   = $clog2(LINE_CHARS + 1);
   localparam int AW   = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
   localparam int CNTW = $clog2(LINE_CHARS + 2);
   localparam int CW   = (PW > CAP_W) ? PW : CAP_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_ONE  = 4'd1;
   localparam logic [3:0] ST_CR2  = 4'd2;
   localparam logic [3:0] ST_BS   = 4'd3;
   localparam logic [3:0] ST_SP   = 4'd4;
   localparam logic [3:0] ST_CRD  = 4'd5;
   localparam logic [3:0] ST_CEM  = 4'd6;
   localparam logic [3:0] ST_DCHK = 4'd7;
   localparam logic [3:0] ST_DRD  = 4'd8;
   localparam logic [3:0] ST_DEM  = 4'd9;
   localparam logic [3:0] ST_DSP  = 4'd10;
   localparam logic [3:0] ST_ICHK = 4'd11;
   localparam logic [3:0] ST_IRD  = 4'd12;
   localparam logic [3:0] ST_IWR  = 4'd13;

   logic [7:0]       line_mem [LINE_CHARS];

   logic [3:0]       state_ff, state_in;
   logic [PW-1:0]    cur_ff, cur_in;
   logic [PW-1:0]    len_ff, len_in;
   logic [PW-1:0]    x_ff, x_in;
   logic [PW-1:0]    stop_ff, stop_in;
   logic [PW-1:0]    aux_ff, aux_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   op_type           op_ff, op_in;
   logic [7:0]       one_byte_ff, one_byte_in;
   logic             one_last_ff, one_last_in;
   logic             bs_last_ff, bs_last_in;
   logic             kph_ff, kph_in;
   logic             kind_ff, kind_in;
   logic             final_ff, final_in;
   logic             done_ff, done_in;
   logic [LEN_W-1:0] done_len_ff, done_len_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [7:0]       rd_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             kind_out_ff;
   logic [7:0]       byte_out_ff;
   logic             done_out_ff;
   logic [LEN_W-1:0] len_out_ff;
   logic             last_out_ff;

   logic [PW-1:0]    cap_eff;
   logic [PW-1:0]    cur_p1, cur_m1, len_p1, len_m1, x_p1, x_m1;
   logic             out_free;
   logic             emit;
   logic             e_kind;
   logic [7:0]       e_byte;
   logic             e_last;
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [7:0]       mem_wd;
   logic             mem_re;
   logic [AW-1:0]    mem_ra;

   assign cap_eff = (CW'(cap_ff) > CW'(LINE_CHARS)) ? PW'(LINE_CHARS) : PW'(cap_ff);
   assign cur_p1  = cur_ff + PW'(1);
   assign cur_m1  = cur_ff - PW'(1);
   assign len_p1  = len_ff + PW'(1);
   assign len_m1  = len_ff - PW'(1);
   assign x_p1    = x_ff + PW'(1);
   assign x_m1    = x_ff - PW'(1);
   assign out_free = !rsp_valid_ff || rsp_pop;
   assign cap_in  = csr_valid ? csr_line_capacity : cap_ff;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      len_in      = len_ff;
      x_in        = x_ff;
      stop_in     = stop_ff;
      aux_in      = aux_ff;
      cnt_in      = cnt_ff;
      op_in       = op_ff;
      one_byte_in = one_byte_ff;
      one_last_in = one_last_ff;
      bs_last_in  = bs_last_ff;
      kph_in      = kph_ff;
      kind_in     = kind_ff;
      final_in    = final_ff;
      done_in     = done_ff;
      done_len_in = done_len_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = cur_ff[AW-1:0];
      mem_wd      = cmd_head.key;
      mem_re      = 1'b0;
      mem_ra      = x_ff[AW-1:0];
      emit        = 1'b0;
      e_kind      = 1'b0;
      e_byte      = CH_SPACE;
      e_last      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               op_in      = cmd_head.op;
               done_in    = 1'b0;
               kind_in    = 1'b0;
               final_in   = 1'b1;
               bs_last_in = 1'b1;
               kph_in     = 1'b0;
               unique case (cmd_head.op)
                  OP_KILL: begin
                     cnt_in     = CNTW'(cur_ff);
                     aux_in     = len_ff;
                     bs_last_in = (len_ff == '0);
                     cur_in     = '0;
                     len_in     = '0;
                     state_in   = ST_BS;
                  end
                  OP_HOME: begin
                     cnt_in   = CNTW'(cur_ff);
                     cur_in   = '0;
                     state_in = ST_BS;
                  end
                  OP_BACK: begin
                     if (cur_ff != '0) begin
                        cur_in      = cur_m1;
                        one_byte_in = CH_BS;
                        one_last_in = 1'b1;
                        state_in    = ST_ONE;
                     end
                  end
                  OP_FWD: begin
                     if (cur_ff < cap_eff && cur_ff < len_ff) begin
                        x_in     = cur_ff;
                        stop_in  = cur_p1;
                        cur_in   = cur_p1;
                        state_in = ST_CRD;
                     end
                  end
                  OP_END: begin
                     if (cur_ff < len_ff) begin
                        x_in     = cur_ff;
                        stop_in  = len_ff;
                        cur_in   = len_ff;
                        state_in = ST_CRD;
                     end
                  end
                  OP_BKSP: begin
                     // step back, then delete under the new cursor
                     if (cur_ff != '0) begin
                        x_in        = cur_m1;
                        stop_in     = len_m1;
                        cnt_in      = CNTW'(len_ff) - CNTW'(cur_ff) + CNTW'(1);
                        cur_in      = cur_m1;
                        len_in      = len_m1;
                        one_byte_in = CH_BS;
                        one_last_in = 1'b0;
                        state_in    = ST_ONE;
                     end
                  end
                  OP_DEL: begin
                     if (cur_ff < len_ff) begin
                        x_in     = cur_ff;
                        stop_in  = len_m1;
                        cnt_in   = CNTW'(len_ff) - CNTW'(cur_ff);
                        len_in   = len_m1;
                        state_in = ST_DCHK;
                     end
                  end
                  OP_INS: begin
                     if (cur_ff < len_ff &&
                         ({1'b0, len_ff} + (PW+1)'(1)) < {1'b0, cap_eff}) begin
                        x_in     = len_ff;
                        stop_in  = len_p1;
                        cnt_in   = CNTW'(len_p1) - CNTW'(cur_ff);
                        len_in   = len_p1;
                        final_in = 1'b0;
                        state_in = ST_ICHK;
                     end
                  end
                  OP_EOL: begin
                     done_in     = 1'b1;
                     done_len_in = LEN_W'(len_ff);
                     aux_in      = len_ff;
                     x_in        = '0;
                     stop_in     = len_ff;
                     kind_in     = 1'b1;
                     cur_in      = '0;
                     len_in      = '0;
                     one_byte_in = CH_LF;
                     one_last_in = 1'b0;
                     state_in    = ST_ONE;
                  end
                  default: begin
                     one_last_in = 1'b1;
                     state_in    = ST_ONE;
                     if (cur_ff >= cap_eff) begin
                        one_byte_in = CH_BELL;
                     end else begin
                        mem_we      = 1'b1;
                        one_byte_in = cmd_head.key;
                        cur_in      = cur_p1;
                        if (cur_p1 > len_ff) begin
                           len_in = cur_p1;
                        end
                     end
                  end
               endcase
            end
         end
         ST_ONE: begin
            emit   = 1'b1;
            e_byte = one_byte_ff;
            e_last = one_last_ff;
            if (out_free) begin
               unique case (op_ff)
                  OP_BKSP: state_in = ST_DCHK;
                  OP_INS:  state_in = ST_CRD;
                  OP_EOL:  state_in = ST_CR2;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CR2: begin
            emit   = 1'b1;
            e_byte = CH_CR;
            e_last = (aux_ff == '0);
            if (out_free) begin
               state_in = (aux_ff == '0) ? ST_IDLE : ST_CRD;
            end
         end
         ST_BS: begin
            if (cnt_ff == '0) begin
               if (op_ff == OP_KILL && !kph_ff) begin
                  cnt_in   = CNTW'(aux_ff);
                  state_in = ST_SP;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               emit   = 1'b1;
               e_byte = CH_BS;
               e_last = bs_last_ff && (cnt_ff == CNTW'(1));
               if (out_free) begin
                  cnt_in = cnt_ff - CNTW'(1);
               end
            end
         end
         ST_SP: begin
            if (cnt_ff == '0) begin
               cnt_in     = CNTW'(aux_ff);
               bs_last_in = 1'b1;
               kph_in     = 1'b1;
               state_in   = ST_BS;
            end else begin
               emit = 1'b1;
               if (out_free) begin
                  cnt_in = cnt_ff - CNTW'(1);
               end
            end
         end
         ST_CRD: begin
            mem_re   = 1'b1;
            state_in = ST_CEM;
         end
         ST_CEM: begin
            emit   = 1'b1;
            e_kind = kind_ff;
            e_byte = rd_ff;
            e_last = final_ff && (x_p1 == stop_ff);
            if (out_free) begin
               x_in = x_p1;
               if (x_p1 == stop_ff) begin
                  state_in = (op_ff == OP_INS) ? ST_BS : ST_IDLE;
               end else begin
                  state_in = ST_CRD;
               end
            end
         end
         ST_DCHK: begin
            state_in = (x_ff < stop_ff) ? ST_DRD : ST_DSP;
         end
         ST_DRD: begin
            mem_re   = 1'b1;
            mem_ra   = x_p1[AW-1:0];
            state_in = ST_DEM;
         end
         ST_DEM: begin
            // shifted char is also the echo for this position
            emit   = 1'b1;
            e_byte = rd_ff;
            if (out_free) begin
               mem_we   = 1'b1;
               mem_wa   = x_ff[AW-1:0];
               mem_wd   = rd_ff;
               x_in     = x_p1;
               state_in = ST_DCHK;
            end
         end
         ST_DSP: begin
            emit = 1'b1;
            if (out_free) begin
               state_in = ST_BS;
            end
         end
         ST_ICHK: begin
            if (x_ff > cur_ff) begin
               state_in = ST_IRD;
            end else begin
               mem_we      = 1'b1;
               mem_wa      = x_ff[AW-1:0];
               mem_wd      = CH_SPACE;
               x_in        = cur_p1;
               one_byte_in = CH_SPACE;
               one_last_in = 1'b0;
               state_in    = ST_ONE;
            end
         end
         ST_IRD: begin
            mem_re   = 1'b1;
            mem_ra   = x_m1[AW-1:0];
            state_in = ST_IWR;
         end
         ST_IWR: begin
            mem_we   = 1'b1;
            mem_wa   = x_ff[AW-1:0];
            mem_wd   = rd_ff;
            x_in     = x_m1;
            state_in = ST_ICHK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         len_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         len_ff       <= len_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      stop_ff     <= stop_in;
      aux_ff      <= aux_in;
      cnt_ff      <= cnt_in;
      op_ff       <= op_in;
      one_byte_ff <= one_byte_in;
      one_last_ff <= one_last_in;
      bs_last_ff  <= bs_last_in;
      kph_ff      <= kph_in;
      kind_ff     <= kind_in;
      final_ff    <= final_in;
      done_ff     <= done_in;
      done_len_ff <= done_len_in;
   end

   always_ff @(posedge clock) begin
      if (emit && out_free) begin
         kind_out_ff <= e_kind;
         byte_out_ff <= e_byte;
         last_out_ff <= e_last;
         done_out_ff <= e_last && done_ff;
         len_out_ff  <= (e_last && done_ff) ? done_len_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= line_mem[mem_ra];
      end
   end

   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_out_kind    = kind_out_ff;
   assign rsp_out_byte    = byte_out_ff;
   assign rsp_line_done   = done_out_ff;
   assign rsp_line_length = len_out_ff;
   assign rsp_last        = last_out_ff;

`ifndef SYNTHESIS
   cur_le_len_a: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= len_ff)
      else $error("cursor beyond line end");

   len_le_max_a: assert property (@(posedge clock) disable iff (reset)
      len_ff <= PW'(LINE_CHARS))
      else $error("line length beyond store depth");

   run_in_range_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CEM |-> x_ff < stop_ff)
      else $error("char run index past its end");

   ins_shift_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IWR |-> (x_ff > cur_ff && x_ff < PW'(LINE_CHARS)))
      else $error("insert shift outside the line");
`endif

endmodule

// ===== test/serial_line_editor_core_test.sv =====
module serial_line_editor_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sle_pkg::*;

   localparam int LINE_CHARS   = 16;
   localparam int QUIET_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 500;
   localparam int PHASE_ITEMS  = 32;

   typedef struct {
      logic             kind;
      logic [7:0]       data;
      logic             done;
      logic [LEN_W-1:0] length;
      logic             last;
   } echo_item_type;

   // Mirror of the editor: line buffer, cursor, length and capacity.
   class line_editor_model;
      logic [7:0]       store [LINE_CHARS];
      logic [LEN_W-1:0] cursor;
      logic [LEN_W-1:0] len;
      logic [CAP_W-1:0] capacity;
      echo_item_type    burst [$];
      echo_item_type    echo_due [$];
      int               mismatches;

      function new();
         foreach (store[i]) store[i] = 8'h00;
         cursor     = '0;
         len        = '0;
         capacity   = CAP_RESET;
         mismatches = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function void add_item(logic kind, logic [7:0] data);
         echo_item_type it;
         it.kind   = kind;
         it.data   = data;
         it.done   = 1'b0;
         it.length = '0;
         it.last   = 1'b0;
         burst.push_back(it);
      endfunction

      function void delete_here();
         int x;
         if (cursor >= len) return;
         for (x = cursor; x + 1 < len && x + 1 < LINE_CHARS; x++) store[x] = store[x + 1];
         len--;
         for (x = cursor; x < len; x++) add_item(1'b0, store[x]);
         add_item(1'b0, CH_SPACE);
         for (x = len + 1; x > cursor; x--) add_item(1'b0, CH_BS);
      endfunction

      function void note_key(logic [7:0] key);
         int               lim;
         int               x;
         logic             finished;
         logic [LEN_W-1:0] done_len;
         echo_item_type    tail;
         lim      = (capacity > LINE_CHARS) ? LINE_CHARS : capacity;
         finished = 1'b0;
         done_len = '0;
         burst.delete();
         case (key)
            KEY_KILL: begin
               for (; cursor > 0; cursor--) add_item(1'b0, CH_BS);
               for (; cursor < len; cursor++) add_item(1'b0, CH_SPACE);
               len = '0;
               for (; cursor > 0; cursor--) add_item(1'b0, CH_BS);
            end
            KEY_HOME: begin
               for (; cursor > 0; cursor--) add_item(1'b0, CH_BS);
            end
            KEY_BACK: begin
               if (cursor > 0) begin
                  cursor--;
                  add_item(1'b0, CH_BS);
               end
            end
            KEY_FWD: begin
               // echo the character under the cursor, then step over it
               if (cursor < lim && cursor < len) begin
                  add_item(1'b0, store[cursor]);
                  cursor++;
               end
            end
            KEY_END: begin
               for (; cursor < len; cursor++) add_item(1'b0, store[cursor]);
            end
            KEY_BS, KEY_RUBOUT: begin
               if (cursor > 0) begin
                  cursor--;
                  add_item(1'b0, CH_BS);
                  delete_here();
               end
            end
            KEY_DEL: begin
               delete_here();
            end
            KEY_TAB: begin
               if (cursor < len && len + 1 < lim) begin
                  for (x = len; x > cursor; x--)
                     if (x < LINE_CHARS) store[x] = store[x - 1];
                  store[cursor] = CH_SPACE;
                  len++;
                  add_item(1'b0, CH_SPACE);
                  for (x = cursor + 1; x < len; x++) add_item(1'b0, store[x]);
                  for (x = cursor; x < len; x++) add_item(1'b0, CH_BS);
               end
            end
            KEY_CR, KEY_LF: begin
               add_item(1'b0, CH_LF);
               add_item(1'b0, CH_CR);
               for (x = 0; x < len; x++) add_item(1'b1, store[x]);
               finished = 1'b1;
               done_len = len;
               cursor   = '0;
               len      = '0;
            end
            default: begin
               if (cursor >= lim) begin
                  add_item(1'b0, CH_BELL);
               end else begin
                  store[cursor] = key;
                  cursor++;
                  add_item(1'b0, key);
                  if (cursor > len) len = cursor;
               end
            end
         endcase
         if (burst.size() > 0) begin
            tail      = burst.pop_back();
            tail.last = 1'b1;
            if (finished) begin
               tail.done   = 1'b1;
               tail.length = done_len;
            end
            burst.push_back(tail);
         end
         foreach (burst[i]) echo_due.push_back(burst[i]);
      endfunction

      function void check_echo(logic kind, logic [7:0] data, logic done,
                               logic [LEN_W-1:0] length, logic last);
         echo_item_type want;
         if (echo_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: kind %0d byte %02h done %0d len %0d last %0d",
                        kind, data, done, length, last);
            return;
         end
         want = echo_due.pop_front();
         if (want.kind !== kind || want.data !== data || want.done !== done ||
             want.length !== length || want.last !== last) begin
            mismatches++;
            // fields in order kind, byte, done, len, last
            if (mismatches <= 10)
               $display("mismatch: expected %0d %02h %0d %0d %0d, got %0d %02h %0d %0d %0d",
                        want.kind, want.data, want.done, want.length, want.last,
                        kind, data, done, length, last);
         end
      endfunction
   endclass

   logic             clock             = 1'b0;
   logic             reset             = 1'b1;
   logic             req_push          = 1'b0;
   logic [7:0]       req_key_byte      = 8'h00;
   logic             rsp_pop           = 1'b0;
   logic             csr_valid         = 1'b0;
   logic [CAP_W-1:0] csr_line_capacity = CAP_RESET;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_out_kind;
   logic [7:0]       rsp_out_byte;
   logic             rsp_line_done;
   logic [LEN_W-1:0] rsp_line_length;
   logic             rsp_last;
   logic             csr_ready;

   line_editor_model model = new();
   logic             tx_steady   = 1'b0;
   logic             rx_steady   = 1'b0;
   int               rx_hold_len = 0;

   serial_line_editor_core #(.LINE_CHARS(LINE_CHARS)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_key_byte      (req_key_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_line_done     (rsp_line_done),
      .rsp_line_length   (rsp_line_length),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_line_capacity (csr_line_capacity)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // result side: check accepted items, then pick pop for the next edge
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            model.check_echo(rsp_out_kind, rsp_out_byte, rsp_line_done, rsp_line_length,
                             rsp_last);
         if (rx_hold_len > 0) begin
            rx_hold_len--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !reset && (rx_steady || $urandom_range(0, 99) >= 30);
         end
      end
   end

   task automatic send_key(input logic [7:0] key);
      req_push     <= 1'b1;
      req_key_byte <= key;
      @(posedge clock);
      while (req_full) @(posedge clock);
      model.note_key(key);
   endtask

   task automatic send_paced(input logic [7:0] key);
      send_key(key);
      if (!tx_steady && $urandom_range(0, 99) < 30) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // block may still be chewing on a key that echoes nothing, so idle a while
   task automatic wait_drained();
      req_push <= 1'b0;
      while (model.echo_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_valid         <= 1'b1;
      csr_line_capacity <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model.set_capacity(value);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   function automatic logic [7:0] pick_edit_key();
      case ($urandom_range(0, 9))
         0: return KEY_HOME;
         1: return KEY_BACK;
         2: return KEY_FWD;
         3: return KEY_END;
         4: return KEY_BS;
         5: return KEY_RUBOUT;
         6: return KEY_DEL;
         7: return KEY_TAB;
         8: return KEY_KILL;
         default: return pick_char();
      endcase
   endfunction

   // mostly a typed line, some edits and a terminator; now and then raw noise
   task automatic send_random_line(output int count);
      int n;
      int i;
      count = 0;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) send_paced(8'($urandom_range(0, 255)));
         count = n;
         return;
      end
      n = $urandom_range(0, 18);
      for (i = 0; i < n; i++) send_paced(pick_char());
      count = n;
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) send_paced(pick_edit_key());
      count += n;
      case ($urandom_range(0, 9))
         0: begin
            send_paced(KEY_KILL);
            count++;
         end
         1: ;
         2, 3, 4, 5: begin
            send_paced(KEY_CR);
            count++;
         end
         default: begin
            send_paced(KEY_LF);
            count++;
         end
      endcase
   endtask

   initial begin
      logic [CAP_W-1:0] phase_caps [10];
      int               sent;
      int               got;
      phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd16, 5'd16, 5'd2, 5'd3, 5'd15};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty line: nothing to move or delete, then finish with length zero
      send_paced(KEY_HOME);
      send_paced(KEY_BACK);
      send_paced(KEY_FWD);
      send_paced(KEY_DEL);
      send_paced(KEY_TAB);
      send_paced(KEY_CR);
      send_paced(8'h00);
      send_paced(8'hFF);
      send_paced(8'h41);
      send_paced(KEY_HOME);
      send_paced(KEY_FWD);
      send_paced(KEY_TAB);
      send_paced(KEY_END);
      send_paced(KEY_BS);
      send_paced(KEY_RUBOUT);
      send_paced(KEY_HOME);
      send_paced(KEY_DEL);
      send_paced(KEY_KILL);
      send_paced(KEY_LF);

      // zero capacity rings the bell
      wait_drained();
      write_capacity(5'd0);
      send_paced(8'h55);

      // capacity above the buffer saturates, then gets lowered under a live line
      wait_drained();
      write_capacity(5'd31);
      send_paced(8'h31);
      send_paced(8'h32);
      send_paced(8'h33);
      wait_drained();
      write_capacity(5'd1);
      send_paced(KEY_HOME);
      send_paced(KEY_FWD);
      send_paced(KEY_FWD);
      send_paced(8'h34);
      send_paced(KEY_KILL);

      for (int ph = 0; ph < 10; ph++) begin
         wait_drained();
         if (ph == 4 || ph == 8) phase_caps[ph] = CAP_W'($urandom_range(0, 31));
         write_capacity(phase_caps[ph]);
         tx_steady = (ph == 6);
         rx_steady = (ph == 6);
         if (ph == 7) rx_hold_len = HOLD_CYCLES;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            send_random_line(got);
            sent += got;
         end
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;

      wait_drained();
      if (model.mismatches == 0 && model.echo_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/sle_pkg.sv
sv/sle_front.sv
sv/sle_back.sv
sv/serial_line_editor_core.sv
test/serial_line_editor_core_test.sv
